>>> rtl/gmps_pkg.sv
// Shared types, constants and helpers for the grid max path sum block.
`default_nettype none
package gmps_pkg;

   localparam int COST_W  = 16;
   localparam int TOTAL_W = 22;
   localparam int SUM_W   = TOTAL_W + 1;
   localparam int CFG_W   = 6;
   localparam int CSR_IDX_W = 1;

   typedef logic signed [COST_W-1:0]  cost_type;
   typedef logic signed [TOTAL_W-1:0] total_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic [CFG_W-1:0]          cfg_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;

   // register indexes
   localparam csr_idx_type REG_GRID_ROWS = 1'b0;
   localparam csr_idx_type REG_GRID_COLS = 1'b1;

   localparam total_type TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
   localparam total_type TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

   // position flags of a cell within its grid
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic last;
   } pos_type;

   // clamp a widened sum back into the total range
   function automatic total_type sat_total(sum_type s);
      total_type r;
      if (s[SUM_W-1] && !s[SUM_W-2]) begin
         r = TOTAL_MIN;
      end else if (!s[SUM_W-1] && s[SUM_W-2]) begin
         r = TOTAL_MAX;
      end else begin
         r = s[TOTAL_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/gmps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gmps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/gmps_seq.sv
// Grid size registers and row/column position sequencer.
`default_nettype none
module gmps_seq #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32,
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire gmps_pkg::csr_idx_type csr_index,
   input  wire gmps_pkg::cfg_type    csr_wdata,
   input  wire logic                 step,
   output logic [CW-1:0]             col,
   output gmps_pkg::pos_type         pos
);
   import gmps_pkg::*;

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   cfg_type         grid_rows_ff, grid_rows_in;
   cfg_type         grid_cols_ff, grid_cols_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   last_row;
   logic [CW-1:0]   last_col;
   logic            row_end;
   logic            col_end;

   // zero acts as one, anything above the maximum as the maximum
   function automatic int last_index(cfg_type v, int maxv);
      int lim;
      if (v == '0) begin
         lim = 1;
      end else if (int'(v) > maxv) begin
         lim = maxv;
      end else begin
         lim = int'(v);
      end
      return lim - 1;
   endfunction

   assign last_row = RW'(last_index(grid_rows_ff, MAX_ROWS));
   assign last_col = CW'(last_index(grid_cols_ff, MAX_COLS));
   assign row_end  = (row_ff == last_row);
   assign col_end  = (col_ff == last_col);

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_GRID_ROWS: grid_rows_in = csr_wdata;
            REG_GRID_COLS: grid_cols_in = csr_wdata;
            default:       grid_rows_in = grid_rows_ff;
         endcase
         row_in = '0;
         col_in = '0;
      end else if (step) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= cfg_type'(1);
         grid_cols_ff <= cfg_type'(1);
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   assign col           = col_ff;
   assign pos.first_row = (row_ff == '0);
   assign pos.first_col = (col_ff == '0);
   assign pos.last      = row_end && col_end;

endmodule
`default_nettype wire

>>> rtl/grid_max_path_sum.sv
// Top level of the grid maximum right/down path sum block.
`default_nettype none
// Cell costs arrive one per req transaction in row-major order; after the
// bottom-right cell of each grid the largest total over all right/down paths
// from the top-left cell is returned as one rsp transaction. Grid size comes
// from csr register 0 (rows) and 1 (columns); zero counts as one and values
// above MAX_ROWS / MAX_COLS count as the maximum. Any csr write restarts the
// grid, dropping a partial one. Throughput is one cell per clock: the best
// totals of the row above live in a MAX_COLS-deep RAM whose single read port
// is addressed as a cell is accepted, and the compare/add/write-back happens
// in the compute stage (the column just written is forwarded to a read of the
// same column). A total passes the compute stage and then the result register.
// req_ready only drops when a total is still waiting on rsp and the cell in
// the compute stage is itself a last cell. Totals saturate to the 22-bit
// signed range. No clearing pass is needed after reset.
module grid_max_path_sum #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire gmps_pkg::cost_type    req_cell_cost,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output gmps_pkg::total_type        rsp_path_total,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire gmps_pkg::csr_idx_type csr_index,
   input  wire gmps_pkg::cfg_type     csr_wdata
);
   import gmps_pkg::*;

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   // position of the next cell
   logic          req_take;
   logic          csr_take;
   logic [CW-1:0] cur_col;
   pos_type       cur_pos;

   // compute stage
   logic          s1_valid_ff, s1_valid_in;
   cost_type      s1_cost_ff;
   pos_type       s1_pos_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_fwd_ff;
   logic          advance;

   total_type     left_best_ff;
   total_type     above;
   total_type     best;
   total_type     base;
   total_type     total;
   total_type     ram_rdata;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   total_type     rsp_total_ff;

   // Stage stalls only when its last-cell total has nowhere to go.
   assign advance   = !(s1_valid_ff && s1_pos_ff.last && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;
   assign req_take  = req_valid && advance;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid;

   gmps_seq #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_take),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (req_take),
      .col       (cur_col),
      .pos       (cur_pos)
   );

   // Row buffer: read the column above as the cell is taken, write back
   // the new total from the compute stage.
   gmps_ram #(
      .WIDTH (TOTAL_W),
      .DEPTH (MAX_COLS)
   ) u_row_best (
      .clock   (clock),
      .wr_en   (s1_valid_ff && advance),
      .wr_addr (s1_col_ff),
      .wr_data (total),
      .rd_en   (advance),
      .rd_addr (cur_col),
      .rd_data (ram_rdata)
   );

   // Same column written in the cycle of the read: that total is left_best.
   assign above = s1_fwd_ff ? left_best_ff : ram_rdata;
   assign best  = (above > left_best_ff) ? above : left_best_ff;

   always_comb begin
      if (s1_pos_ff.first_row && s1_pos_ff.first_col) begin
         base = '0;
      end else if (s1_pos_ff.first_row) begin
         base = left_best_ff;
      end else if (s1_pos_ff.first_col) begin
         base = above;
      end else begin
         base = best;
      end
   end

   assign total = sat_total(sum_type'(base) + sum_type'(s1_cost_ff));

   assign s1_valid_in = advance ? req_take : s1_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_valid_ff && advance && s1_pos_ff.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_best_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && advance) begin
            left_best_ff <= total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cost_ff <= req_cell_cost;
         s1_pos_ff  <= cur_pos;
         s1_col_ff  <= cur_col;
         s1_fwd_ff  <= s1_valid_ff && (s1_col_ff == cur_col);
      end
      if (s1_valid_ff && advance && s1_pos_ff.last) begin
         rsp_total_ff <= total;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_total = rsp_total_ff;

endmodule
`default_nettype wire
